>>> rtl/wiegand_frame_transmitter_macros.svh
// Assertion helpers shared by the RTL of the Wiegand frame transmitter.
`ifndef WIEGAND_FRAME_TRANSMITTER_MACROS_SVH
`define WIEGAND_FRAME_TRANSMITTER_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define WFT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset (clk_i, rst_ni).
`define WFT_ASSERT(label, prop, msg) \
  `WFT_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/wft_pkg.sv
package wft_pkg;

  localparam int PAYLOAD_W  = 64;
  localparam int LEN_W      = 7;
  localparam int TICK_W     = 16;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [LEN_W-1:0]  FRAME_LENGTH_RST = 7'd26;
  localparam logic [TICK_W-1:0] PULSE_TICKS_RST  = 16'd100;
  localparam logic [TICK_W-1:0] PERIOD_TICKS_RST = 16'd1000;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

  // Register index, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_FRAME_LENGTH    = 3'd0,
    REG_PARITY_ENABLE   = 3'd1,
    REG_REVERSE_ORDER   = 3'd2,
    REG_PARITY_INVERTED = 3'd3,
    REG_PULSE_TICKS     = 3'd4,
    REG_PERIOD_TICKS    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [PAYLOAD_W-1:0] payload;
  } item_t;

  typedef struct packed {
    logic strobe_line;
    logic data_line;
    logic busy_res;
    logic frame_done;
    logic start_refused;
  } result_t;

  // Frame shape handed to the frame builder; len is already clamped.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             parity_enable;
    logic             reverse_order;
    logic             parity_inverted;
  } frame_cfg_t;

endpackage

>>> rtl/wft_item_if.sv
interface wft_item_if import wft_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/wft_result_if.sv
interface wft_result_if import wft_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/wiegand_frame_transmitter.sv
// Wiegand frame transmitter. Each input beat is either a start command,
// which latches a 64-bit payload and builds a frame of up to MAX_FRAME_BITS
// bits (data from the top of the payload, optional even and odd parity
// slots at either end), or a time tick, which advances the bit timing.
// Every accepted beat produces exactly one result beat showing the strobe
// and data line levels, the busy flag, a done flag on the tick that closes
// the frame and a refused flag for a start that arrived while busy. The
// block takes one beat per clock cycle: its work is a single pass of
// short logic from the state registers into the result register, and a
// new beat is taken whenever the result register is empty or is being
// read in the same cycle, so the result of a beat is offered on the cycle
// after it is accepted. Frame shape (length, parity, order) is latched at
// start; pulse and period registers act at once. No clearing pass runs
// after reset, so the block is ready on the first cycle out of reset.
`include "wiegand_frame_transmitter_macros.svh"

module wiegand_frame_transmitter import wft_pkg::*; #(
  parameter int MAX_FRAME_BITS = 66
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  wft_item_if.sink              item_i,
  wft_result_if.source          result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W = $clog2(MAX_FRAME_BITS + 1);
  localparam int SEL_W = $clog2(MAX_FRAME_BITS);

  // ---------------------------------------------------------------------
  // Configuration registers. Writes complete in the APB access phase; the
  // port never inserts wait states.
  // ---------------------------------------------------------------------
  logic [LEN_W-1:0]  cfg_len_q;
  logic              cfg_par_q;
  logic              cfg_rev_q;
  logic              cfg_inv_q;
  logic [TICK_W-1:0] cfg_pulse_q;
  logic [TICK_W-1:0] cfg_period_q;
  logic              cfg_wr;
  cfg_reg_e          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q    <= FRAME_LENGTH_RST;
      cfg_par_q    <= 1'b1;
      cfg_rev_q    <= 1'b0;
      cfg_inv_q    <= 1'b0;
      cfg_pulse_q  <= PULSE_TICKS_RST;
      cfg_period_q <= PERIOD_TICKS_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_FRAME_LENGTH:    cfg_len_q    <= pwdata[LEN_W-1:0];
        REG_PARITY_ENABLE:   cfg_par_q    <= pwdata[0];
        REG_REVERSE_ORDER:   cfg_rev_q    <= pwdata[0];
        REG_PARITY_INVERTED: cfg_inv_q    <= pwdata[0];
        REG_PULSE_TICKS:     cfg_pulse_q  <= pwdata[TICK_W-1:0];
        REG_PERIOD_TICKS:    cfg_period_q <= pwdata[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_FRAME_LENGTH:    prdata = CFG_DATA_W'(cfg_len_q);
      REG_PARITY_ENABLE:   prdata = CFG_DATA_W'(cfg_par_q);
      REG_REVERSE_ORDER:   prdata = CFG_DATA_W'(cfg_rev_q);
      REG_PARITY_INVERTED: prdata = CFG_DATA_W'(cfg_inv_q);
      REG_PULSE_TICKS:     prdata = CFG_DATA_W'(cfg_pulse_q);
      REG_PERIOD_TICKS:    prdata = CFG_DATA_W'(cfg_period_q);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Frame builder. A frame longer than the store is cut to MAX_FRAME_BITS.
  // ---------------------------------------------------------------------
  frame_cfg_t                fcfg;
  logic [LEN_W-1:0]          len_clamp;
  logic [MAX_FRAME_BITS-1:0] frame_new;

  assign len_clamp = (int'(cfg_len_q) > MAX_FRAME_BITS) ?
                     LEN_W'(MAX_FRAME_BITS) : cfg_len_q;

  assign fcfg.len             = len_clamp;
  assign fcfg.parity_enable   = cfg_par_q;
  assign fcfg.reverse_order   = cfg_rev_q;
  assign fcfg.parity_inverted = cfg_inv_q;

  wft_frame_build #(
    .MAX_FRAME_BITS(MAX_FRAME_BITS)
  ) u_frame_build (
    .cfg_i    (fcfg),
    .payload_i(item_i.data.payload),
    .frame_o  (frame_new)
  );

  // ---------------------------------------------------------------------
  // Transmit state. It moves only when a beat is accepted, and a beat is
  // accepted only when its result can be loaded in the same edge.
  // ---------------------------------------------------------------------
  logic [MAX_FRAME_BITS-1:0] frame_q, frame_d;
  logic [IDX_W-1:0]          len_q, len_d;
  logic [IDX_W-1:0]          bit_idx_q, bit_idx_d;
  logic [TICK_W-1:0]         tick_q, tick_d;
  logic                      sending_q, sending_d;
  logic                      strobe_q, strobe_d;
  logic                      data_q, data_d;
  logic                      done_d;
  logic                      refused_d;
  logic [TICK_W:0]           tick_next;
  logic                      in_ready;
  logic                      in_accept;
  logic                      out_valid_q, out_valid_d;
  result_t                   res_q, res_d;

  assign in_ready     = !out_valid_q || result_o.ready;
  assign in_accept    = item_i.valid && in_ready;
  assign item_i.ready = in_ready;
  assign tick_next    = {1'b0, tick_q} + (TICK_W + 1)'(1);

  always_comb begin
    frame_d   = frame_q;
    len_d     = len_q;
    bit_idx_d = bit_idx_q;
    tick_d    = tick_q;
    sending_d = sending_q;
    strobe_d  = strobe_q;
    data_d    = data_q;
    done_d    = 1'b0;
    refused_d = 1'b0;

    if (in_accept) begin
      if (item_i.data.cmd == CMD_START) begin
        if (sending_q) begin
          // A start during a frame is dropped and flagged; time stands still.
          refused_d = 1'b1;
        end else begin
          frame_d   = frame_new;
          len_d     = IDX_W'(len_clamp);
          sending_d = 1'b1;
          bit_idx_d = '0;
          tick_d    = '0;
          strobe_d  = 1'b1;
          data_d    = 1'b1;
        end
      end else if (sending_q) begin
        // A period of zero behaves as one, since tick_next is never zero.
        if (tick_next >= {1'b0, cfg_period_q}) begin
          tick_d = '0;
          if (bit_idx_q < len_q) begin
            // Start of a bit: strobe goes low, the data line shows the
            // inverted frame bit.
            data_d    = ~frame_q[bit_idx_q[SEL_W-1:0]];
            strobe_d  = 1'b0;
            bit_idx_d = bit_idx_q + IDX_W'(1);
          end else begin
            // One period after the last bit began, the frame closes.
            sending_d = 1'b0;
            done_d    = 1'b1;
            strobe_d  = 1'b1;
            data_d    = 1'b1;
            bit_idx_d = '0;
          end
        end else begin
          tick_d = tick_next[TICK_W-1:0];
          // The strobe rises once the pulse time has run, but only after
          // the first bit; the idle lead-in period keeps it high anyway.
          if (bit_idx_q != '0 && tick_d >= cfg_pulse_q) begin
            strobe_d = 1'b1;
          end
        end
      end
    end

    res_d.strobe_line   = strobe_d;
    res_d.data_line     = data_d;
    res_d.busy_res      = sending_d;
    res_d.frame_done    = done_d;
    res_d.start_refused = refused_d;

    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      bit_idx_q   <= '0;
      tick_q      <= '0;
      sending_q   <= 1'b0;
      strobe_q    <= 1'b1;
      data_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      bit_idx_q   <= bit_idx_d;
      tick_q      <= tick_d;
      sending_q   <= sending_d;
      strobe_q    <= strobe_d;
      data_q      <= data_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Frame store and result beat carry data only; their control is above.
  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = res_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `WFT_ASSERT(a_done_not_busy, out_valid_q && res_q.frame_done |-> !res_q.busy_res, "frame done while still busy")
  `WFT_ASSERT(a_start_loads, in_accept && item_i.data.cmd == CMD_START && !sending_q |=> sending_q && bit_idx_q == '0, "start while idle did not begin a frame")
  `WFT_ASSERT(a_idx_in_frame, bit_idx_q <= len_q, "bit index ran past the frame")
  `WFT_ASSERT(a_tick_bound, tick_q != '1, "tick counter reached its ceiling")
  `WFT_ASSERT(a_idle_lines_high, !sending_q |-> strobe_q && data_q, "lines not idle high outside a frame")

endmodule

>>> rtl/wft_frame_build.sv
module wft_frame_build import wft_pkg::*; #(
  parameter int MAX_FRAME_BITS = 66
) (
  input  frame_cfg_t                cfg_i,
  input  logic [PAYLOAD_W-1:0]      payload_i,
  output logic [MAX_FRAME_BITS-1:0] frame_o
);

  localparam int EXT_W = PAYLOAD_W + MAX_FRAME_BITS;
  localparam int SH_W  = $clog2(EXT_W + 1);

  logic [LEN_W-1:0]          data_cnt;
  logic [LEN_W-1:0]          mid;
  logic [LEN_W-1:0]          hi_start;
  logic [EXT_W-1:0]          ext;
  logic [EXT_W-1:0]          ext_sh;
  logic [SH_W-1:0]           sh;
  logic [MAX_FRAME_BITS-1:0] d_norm;
  logic [MAX_FRAME_BITS-1:0] d_rev;
  logic [MAX_FRAME_BITS-1:0] d_sel;
  logic [MAX_FRAME_BITS-1:0] m_data;
  logic [MAX_FRAME_BITS-1:0] m_lo;
  logic [MAX_FRAME_BITS-1:0] m_hi;
  logic                      par_lo;
  logic                      par_hi;

  // Number of data slots between the parity slots.
  always_comb begin
    if (!cfg_i.parity_enable) begin
      data_cnt = cfg_i.len;
    end else if (cfg_i.len >= LEN_W'(2)) begin
      data_cnt = cfg_i.len - LEN_W'(2);
    end else begin
      data_cnt = '0;
    end
  end

  // The halves meet in the middle; an odd data count shares its middle bit.
  assign mid      = (cfg_i.len - LEN_W'(1)) >> 1;
  assign hi_start = data_cnt[0] ? mid - LEN_W'(1) : mid;

  // Reverse order: the top data_cnt bits of the payload, lowest first,
  // with zeros ahead of them when the slot count passes the payload width.
  assign ext    = {payload_i, {MAX_FRAME_BITS{1'b0}}};
  assign sh     = SH_W'(EXT_W) - SH_W'(data_cnt);
  assign ext_sh = ext >> sh;
  assign d_rev  = ext_sh[MAX_FRAME_BITS-1:0];

  for (genvar j = 0; j < MAX_FRAME_BITS; j++) begin : g_slot
    if (j < PAYLOAD_W) begin : g_src
      assign d_norm[j] = payload_i[PAYLOAD_W-1-j];
    end else begin : g_pad
      assign d_norm[j] = 1'b0;
    end
    assign m_data[j] = LEN_W'(j) < data_cnt;
    assign m_lo[j]   = LEN_W'(j) < mid;
    assign m_hi[j]   = LEN_W'(j) >= hi_start;
  end

  assign d_sel  = (cfg_i.reverse_order ? d_rev : d_norm) & m_data;
  assign par_lo = ^(d_sel & m_lo);
  assign par_hi = ^(d_sel & m_hi);

  always_comb begin
    if (!cfg_i.parity_enable) begin
      frame_o = d_sel;
    end else begin
      frame_o = {d_sel[MAX_FRAME_BITS-2:0], 1'b0};
      if (cfg_i.len == LEN_W'(1)) begin
        frame_o[0] = ~cfg_i.parity_inverted;
      end else begin
        frame_o[0] = par_lo ^ cfg_i.parity_inverted;
      end
      for (int k = 1; k < MAX_FRAME_BITS; k++) begin
        if (cfg_i.len >= LEN_W'(2) && LEN_W'(k) == cfg_i.len - LEN_W'(1)) begin
          frame_o[k] = ~par_hi ^ cfg_i.parity_inverted;
        end
      end
    end
  end

endmodule
